[hdl/pdd_pkg.sv]
// shared types and constants for the two-wheel pd position drive
// no dependencies; imported by the wheel lane and the top level

package pdd_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned CSR_INDEX_W = 2;

   typedef enum logic {
      OP_COMMAND = 1'b0,
      OP_SENSOR  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_P_GAIN    = 2'd0,
      CSR_D_GAIN    = 2'd1,
      CSR_TOLERANCE = 2'd2
   } csr_index_type;

   localparam logic [WORD_W-1:0] P_GAIN_RESET    = 16'd256;
   localparam logic [WORD_W-1:0] D_GAIN_RESET    = 16'd0;
   localparam logic [WORD_W-1:0] TOLERANCE_RESET = 16'd5;

   localparam logic signed [WORD_W-1:0] SPEED_MAX = 16'sh7fff;
   localparam logic signed [WORD_W-1:0] SPEED_MIN = 16'sh8000;

   typedef struct packed {
      logic [WORD_W-1:0]        p_gain;
      logic [WORD_W-1:0]        d_gain;
      logic [WORD_W-1:0]        tolerance;
   } gains_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] goal;
      logic [WORD_W-1:0]        base;
      logic signed [WORD_W-1:0] progress;
      logic signed [WORD_W-1:0] drive;
   } wheel_state_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] drive;
      logic signed [WORD_W-1:0] progress;
      logic                     err_ok;
      logic                     speed_small;
   } lane_result_type;

endpackage

[hdl/pdd_lane.sv]
// one wheel lane: pd speed law, wrapped travel and completion tests
// depends on pdd_pkg

module pdd_lane import pdd_pkg::*; (
   input  gains_type        gains,
   input  wheel_state_type  wheel,
   input  logic             running,
   input  logic [WORD_W-1:0] encoder,
   output lane_result_type  result
);

   logic signed [WORD_W:0]     err;
   logic signed [WORD_W:0]     p_gain_s;
   logic signed [WORD_W:0]     d_gain_s;
   logic signed [2*WORD_W+1:0] p_term;
   logic signed [2*WORD_W:0]   d_term;
   logic signed [2*WORD_W+2:0] x;
   logic                       neg;
   logic [2*WORD_W+2:0]        mag;
   logic [2*WORD_W+3:0]        mag_rounded;
   logic [2*WORD_W-5:0]        q;
   logic signed [WORD_W-1:0]   pd_speed;
   logic signed [WORD_W-1:0]   new_drive;
   logic [WORD_W-1:0]          travel;
   logic signed [WORD_W:0]     goal_diff;
   logic [WORD_W:0]            goal_dist;

   always_comb begin
      err      = {wheel.goal[WORD_W-1], wheel.goal} -
                 {wheel.progress[WORD_W-1], wheel.progress};
      p_gain_s = {1'b0, gains.p_gain};
      d_gain_s = {1'b0, gains.d_gain};
      p_term   = p_gain_s * err;
      d_term   = d_gain_s * wheel.drive;
      x        = {p_term[2*WORD_W+1], p_term} -
                 {{2{d_term[2*WORD_W]}}, d_term};
      neg      = x[2*WORD_W+2];
      mag      = neg ? (2*WORD_W+3)'(-x) : (2*WORD_W+3)'(x);
      mag_rounded = {1'b0, mag} + (2*WORD_W+4)'(255);
      q        = mag_rounded[2*WORD_W+3:8];
      if (neg) begin
         if (q > (2*WORD_W-4)'(32768)) begin
            pd_speed = SPEED_MIN;
         end else begin
            pd_speed = WORD_W'(-q);
         end
      end else begin
         if (q > (2*WORD_W-4)'(32767)) begin
            pd_speed = SPEED_MAX;
         end else begin
            pd_speed = q[WORD_W-1:0];
         end
      end
      new_drive = running ? pd_speed : wheel.drive;

      travel    = encoder - wheel.base;
      goal_diff = {wheel.goal[WORD_W-1], wheel.goal} - {travel[WORD_W-1], travel};
      goal_dist = goal_diff[WORD_W] ? (WORD_W+1)'(-goal_diff) : goal_diff;

      result.drive       = new_drive;
      result.progress    = travel;
      result.err_ok      = goal_dist < {1'b0, gains.tolerance};
      result.speed_small = (new_drive == 16'sd0) || (new_drive == 16'sd1) ||
                           (new_drive == -16'sd1);
   end

endmodule

[hdl/two_wheel_pd_position_drive.sv]
// top level of the two-wheel pd position drive: registers, csr port,
// two wheel lanes, completion merge and result register; depends on pdd_pkg, pdd_lane
//
// One transaction in, one result out. A transaction can be taken every cycle while
// ready is high: the whole update for both wheels (two multiplies per lane, rounding,
// saturation and the completion test) runs within the accepting cycle, with the two
// lanes side by side, and the result is held in a single output register. Input
// ready follows the output register: high while it is empty or being drained in the
// same cycle. Result valid is registered and rises in the cycle after acceptance.

module two_wheel_pd_position_drive import pdd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic signed [WORD_W-1:0] req_left_target,
   input  logic signed [WORD_W-1:0] req_right_target,
   input  logic [WORD_W-1:0]        req_left_encoder,
   input  logic [WORD_W-1:0]        req_right_encoder,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_left_speed,
   output logic signed [WORD_W-1:0] rsp_right_speed,
   output logic                     rsp_done_res,
   output logic                     rsp_active,
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [WORD_W-1:0]        csr_wdata
);

   gains_type       gains_ff, gains_in;
   wheel_state_type left_ff, left_in, right_ff, right_in;
   logic [WORD_W-1:0] left_last_ff, left_last_in, right_last_ff, right_last_in;
   logic            running_ff, running_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic            rsp_done_ff, rsp_done_in, rsp_active_ff, rsp_active_in;

   lane_result_type left_res, right_res;
   logic            accept;
   logic            done;

   pdd_lane u_left_lane (
      .gains   (gains_ff),
      .wheel   (left_ff),
      .running (running_ff),
      .encoder (req_left_encoder),
      .result  (left_res)
   );

   pdd_lane u_right_lane (
      .gains   (gains_ff),
      .wheel   (right_ff),
      .running (running_ff),
      .encoder (req_right_encoder),
      .result  (right_res)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      gains_in = gains_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_P_GAIN:    gains_in.p_gain    = csr_wdata;
            CSR_D_GAIN:    gains_in.d_gain    = csr_wdata;
            CSR_TOLERANCE: gains_in.tolerance = csr_wdata;
            default:       gains_in = gains_ff;
         endcase
      end
   end

   // command load, merge of the two lanes and response update
   always_comb begin
      left_in       = left_ff;
      right_in      = right_ff;
      left_last_in  = left_last_ff;
      right_last_in = right_last_ff;
      running_in    = running_ff;
      done          = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_active_in = rsp_active_ff;
      if (accept) begin
         unique case (opcode_type'(req_opcode))
            OP_COMMAND: begin
               left_in.goal      = req_left_target;
               right_in.goal     = req_right_target;
               left_in.base      = left_last_ff;
               right_in.base     = right_last_ff;
               left_in.progress  = '0;
               right_in.progress = '0;
               running_in        = 1'b1;
            end
            OP_SENSOR: begin
               left_in.drive     = left_res.drive;
               right_in.drive    = right_res.drive;
               left_in.progress  = left_res.progress;
               right_in.progress = right_res.progress;
               left_last_in      = req_left_encoder;
               right_last_in     = req_right_encoder;
               done = running_ff && left_res.err_ok && right_res.err_ok &&
                      left_res.speed_small && right_res.speed_small;
               if (done) begin
                  left_in.drive  = '0;
                  right_in.drive = '0;
                  running_in     = 1'b0;
               end
            end
            default: running_in = running_ff;
         endcase
         rsp_valid_in  = 1'b1;
         rsp_left_in   = left_in.drive;
         rsp_right_in  = right_in.drive;
         rsp_done_in   = done;
         rsp_active_in = running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff      <= '{p_gain: P_GAIN_RESET, d_gain: D_GAIN_RESET,
                            tolerance: TOLERANCE_RESET};
         left_ff       <= '0;
         right_ff      <= '0;
         left_last_ff  <= '0;
         right_last_ff <= '0;
         running_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gains_ff      <= gains_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         left_last_ff  <= left_last_in;
         right_last_ff <= right_last_in;
         running_ff    <= running_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = rsp_left_ff;
   assign rsp_right_speed = rsp_right_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_active      = rsp_active_ff;

endmodule
